@@ hw/rtl/bucv_pkg.sv @@
package bucv_pkg;

    // datapath widths
    localparam int XW       = 36;   // CORDIC x/y
    localparam int ZW       = 34;   // CORDIC angle accumulator, Q4.30
    localparam int NW       = 64;   // divider dividend / remainder
    localparam int DW       = 48;   // divider divisor
    localparam int QW       = 17;   // quotient bits (top bit marks overflow)
    localparam int ATAN_LEN = 24;

    localparam logic signed [15:0] HALF_PI_Q14 = 16'sd25736;
    localparam logic signed [16:0] PI_Q14      = 17'sd51472;
    localparam logic signed [15:0] SAT_POS     = 16'sh7fff;
    localparam logic signed [15:0] SAT_NEG     = 16'sh8000;
    localparam logic signed [XW-1:0] CORDIC_ONE = 36'sd1073741824;

    localparam logic [15:0] GEOM_RESET = 16'd4096;

    // configuration register indexes
    localparam logic [0:0] REG_WHEEL_RADIUS = 1'b0;
    localparam logic [0:0] REG_WHEELBASE    = 1'b1;

    // side information that travels with an item down the chain
    typedef struct packed {
        logic               mode;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [32:0] p;
        logic signed [15:0] o1;
        logic               f1;
        logic               zdiv;
        logic               neg;
        logic               nz;
    } side_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)
            r = SAT_POS;
        else if (v < -24'sd32768)
            r = SAT_NEG;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic ovf16(input logic signed [23:0] v);
        return (v > 24'sd32767) || (v < -24'sd32768);
    endfunction

endpackage

@@ hw/rtl/bucv_cordic_cell.sv @@
module bucv_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          vld_in,
    input  logic signed [bucv_pkg::XW-1:0] x_in,
    input  logic signed [bucv_pkg::XW-1:0] y_in,
    input  logic signed [bucv_pkg::ZW-1:0] z_in,
    input  bucv_pkg::side_t               side_in,
    output logic                          vld_out,
    output logic signed [bucv_pkg::XW-1:0] x_out,
    output logic signed [bucv_pkg::XW-1:0] y_out,
    output logic signed [bucv_pkg::ZW-1:0] z_out,
    output bucv_pkg::side_t               side_out
);
    import bucv_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE = $signed(ZW'(atan_q30(STAGE)));

    logic                 vld_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;
    side_t                side_reg;
    logic                 y_pos, turn_neg;

    assign xs = x_in >>> STAGE;
    assign ys = y_in >>> STAGE;

    // vectoring (mode 0) drives y toward zero, rotation (mode 1) drives z toward zero
    assign y_pos    = !y_in[XW-1] && (y_in != '0);
    assign turn_neg = side_in.mode ? !z_in[ZW-1] : !y_pos;

    always_comb
    begin
        if (turn_neg)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/bucv_div_cell.sv @@
module bucv_div_cell #(
    parameter int BIT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vld_in,
    input  logic [bucv_pkg::NW-1:0] rem_in,
    input  logic [bucv_pkg::DW-1:0] den_in,
    input  logic [bucv_pkg::QW-1:0] quo_in,
    input  bucv_pkg::side_t        side_in,
    output logic                   vld_out,
    output logic [bucv_pkg::NW-1:0] rem_out,
    output logic [bucv_pkg::DW-1:0] den_out,
    output logic [bucv_pkg::QW-1:0] quo_out,
    output bucv_pkg::side_t        side_out
);
    import bucv_pkg::*;

    logic          vld_reg;
    logic [NW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    side_t         side_reg;
    logic [NW:0]   dsh, diff;
    logic          ge;

    // one restoring step: try to take den << BIT out of the remainder
    assign dsh  = (NW+1)'(den_in) << BIT;
    assign diff = {1'b0, rem_in} - dsh;
    assign ge   = !diff[NW];

    always_comb
    begin
        quo_next      = quo_in;
        quo_next[BIT] = ge;
        rem_next      = ge ? diff[NW-1:0] : rem_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/bicycle_unicycle_kinematic_convert.sv @@
// Unicycle <-> bicycle drive command converter.
// Input channel: in_valid / in_stall with mode, in_first, in_second; a transfer
// happens on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_first, out_second, saturated;
// every input transfer produces exactly one output transfer, in order.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// wheel_radius (0) or wheelbase (1); write only while the block is idle.
// Pipeline: an input stage, one CORDIC cell per iteration (capped at 24
// cells), three multiply/normalize stages, seventeen restoring-divider cells
// and the output register.
// Throughput: one item per cycle while the skid is empty (single-step cells).
// Stall: a two-entry output buffer (output register plus skid) absorbs one
// extra result; once the skid is occupied the whole chain freezes and
// in_stall is raised until the receiver takes a result.
// Reset: all valids clear, both geometry registers return to 1.0 m (4096).
module bicycle_unicycle_kinematic_convert #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] in_first,
    input  logic signed [15:0] in_second,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_first,
    output logic signed [15:0] out_second,
    output logic               saturated
);
    import bucv_pkg::*;

    localparam int NCELL = (ANGLE_ITERATIONS > ATAN_LEN) ? ATAN_LEN : ANGLE_ITERATIONS;

    // ------------------------------------------------------------------
    // configuration registers
    logic [15:0] wheel_radius_reg, wheelbase_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_radius_reg <= GEOM_RESET;
            wheelbase_reg    <= GEOM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WHEEL_RADIUS: wheel_radius_reg <= cfg_data;
                REG_WHEELBASE:    wheelbase_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // chain advances unless the skid slot is holding a result
    logic en_pipe;
    logic skid_vld_reg;

    assign en_pipe  = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // ------------------------------------------------------------------
    // input stage: products and CORDIC start values
    logic signed [32:0]   lw_prod, rb_prod;
    logic signed [16:0]   a_ext, a_abs, d_red;
    logic signed [XW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;
    side_t                side0_next;

    assign lw_prod = $signed({1'b0, wheelbase_reg}) * in_second;
    assign rb_prod = $signed({1'b0, wheel_radius_reg}) * in_second;
    assign a_ext   = 17'(in_first);
    assign a_abs   = a_ext[16] ? -a_ext : a_ext;

    always_comb
    begin
        // steering angle folded into [-pi/2, pi/2]
        if (a_ext > 17'(HALF_PI_Q14))
            d_red = a_ext - PI_Q14;
        else if (a_ext < -17'(HALF_PI_Q14))
            d_red = a_ext + PI_Q14;
        else
            d_red = a_ext;

        if (mode)
        begin
            x0_next = CORDIC_ONE;
            y0_next = '0;
            z0_next = ZW'(d_red) <<< 16;
        end
        else
        begin
            x0_next = XW'({a_abs, 12'd0});
            y0_next = in_first[15] ? -XW'(lw_prod) : XW'(lw_prod);
            z0_next = '0;
        end

        side0_next      = '0;
        side0_next.mode = mode;
        side0_next.a    = in_first;
        side0_next.b    = in_second;
        side0_next.p    = rb_prod;
    end

    logic signed [XW-1:0] cx [0:NCELL];
    logic signed [XW-1:0] cy [0:NCELL];
    logic signed [ZW-1:0] cz [0:NCELL];
    side_t                cside [0:NCELL];
    logic [NCELL:0]       cvld;
    logic                 vld0_reg;
    logic signed [XW-1:0] x0_reg, y0_reg;
    logic signed [ZW-1:0] z0_reg;
    side_t                side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (en_pipe)
            vld0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            z0_reg    <= z0_next;
            side0_reg <= side0_next;
        end
    end

    assign cvld[0]  = vld0_reg;
    assign cx[0]    = x0_reg;
    assign cy[0]    = y0_reg;
    assign cz[0]    = z0_reg;
    assign cside[0] = side0_reg;

    // ------------------------------------------------------------------
    // CORDIC cells, one iteration each
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cordic
        bucv_cordic_cell #(.STAGE(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en_pipe),
            .vld_in   (cvld[i]),
            .x_in     (cx[i]),
            .y_in     (cy[i]),
            .z_in     (cz[i]),
            .side_in  (cside[i]),
            .vld_out  (cvld[i+1]),
            .x_out    (cx[i+1]),
            .y_out    (cy[i+1]),
            .z_out    (cz[i+1]),
            .side_out (cside[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage A: angle rounding, speed, partial products of rate*r*sin, cos*L
    localparam logic signed [ZW-16:0] ZQ_MAX = (ZW-15)'(HALF_PI_Q14);

    side_t                sa_in, sa_next;
    logic signed [ZW:0]   z_sum;
    logic signed [ZW-16:0] z_q;
    logic signed [15:0]   ang_clamp;
    logic signed [33:0]   p_rnd;
    logic signed [23:0]   spd;
    logic signed [31:0]   s32;
    logic signed [15:0]   s_hi;
    logic signed [16:0]   s_lo;
    logic signed [48:0]   pp_hi_next;
    logic signed [49:0]   pp_lo_next;
    logic [DW-1:0]        den_a_next;
    logic                 cpos_next;

    assign sa_in = cside[NCELL];
    assign z_sum = $signed({cz[NCELL][ZW-1], cz[NCELL]}) + (ZW+1)'(32'sd32768);
    assign z_q   = z_sum[ZW:16];
    assign p_rnd = 34'(sa_in.p) + 34'sd2048;
    assign spd   = 24'($signed(p_rnd[33:12]));
    assign s32   = cy[NCELL][31:0];
    assign s_hi  = s32[31:16];
    assign s_lo  = $signed({1'b0, s32[15:0]});

    assign pp_hi_next = $signed(sa_in.p) * s_hi;
    assign pp_lo_next = $signed(sa_in.p) * s_lo;
    assign den_a_next = DW'(cx[NCELL][31:0]) * DW'(wheelbase_reg);
    assign cpos_next  = !cx[NCELL][XW-1] && (cx[NCELL] != '0);

    always_comb
    begin
        if (z_q > ZQ_MAX)
            ang_clamp = HALF_PI_Q14;
        else if (z_q < -ZQ_MAX)
            ang_clamp = -HALF_PI_Q14;
        else
            ang_clamp = z_q[15:0];

        sa_next = sa_in;
        if (sa_in.mode)
        begin
            sa_next.o1 = sat16(spd);
            sa_next.f1 = ovf16(spd);
        end
        else
        begin
            sa_next.f1 = 1'b0;
            if (sa_in.b == '0)
                sa_next.o1 = '0;
            else if (sa_in.a == '0)
                sa_next.o1 = sa_in.b[15] ? -HALF_PI_Q14 : HALF_PI_Q14;
            else
                sa_next.o1 = ang_clamp;
        end
    end

    logic                 vlda_reg;
    side_t                sidea_reg;
    logic signed [48:0]   pp_hi_reg;
    logic signed [49:0]   pp_lo_reg;
    logic [DW-1:0]        den_a_reg;
    logic                 cpos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vlda_reg <= 1'b0;
        else if (en_pipe)
            vlda_reg <= cvld[NCELL];
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            sidea_reg <= sa_next;
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
            den_a_reg <= den_a_next;
            cpos_reg  <= cpos_next;
        end
    end

    // ------------------------------------------------------------------
    // stage B: dividend and divisor for either mode
    logic signed [NW-1:0] num_b_next;
    logic [DW-1:0]        den_b_next;
    side_t                sb_next;

    always_comb
    begin
        sb_next = sidea_reg;
        if (sidea_reg.mode)
        begin
            num_b_next   = (NW'(pp_hi_reg) <<< 16) + NW'(pp_lo_reg);
            den_b_next   = den_a_reg;
            sb_next.zdiv = (wheelbase_reg == '0) || !cpos_reg;
        end
        else
        begin
            num_b_next   = NW'(sidea_reg.a) <<< 12;
            den_b_next   = DW'(wheel_radius_reg);
            sb_next.zdiv = (wheel_radius_reg == '0);
        end
    end

    logic                 vldb_reg;
    side_t                sideb_reg;
    logic signed [NW-1:0] numb_reg;
    logic [DW-1:0]        denb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldb_reg <= 1'b0;
        else if (en_pipe)
            vldb_reg <= vlda_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            sideb_reg <= sb_next;
            numb_reg  <= num_b_next;
            denb_reg  <= den_b_next;
        end
    end

    // ------------------------------------------------------------------
    // stage C: sign and magnitude of the dividend
    side_t         sc_next;
    logic [NW-1:0] mag_next;

    always_comb
    begin
        sc_next     = sideb_reg;
        sc_next.neg = numb_reg[NW-1];
        sc_next.nz  = (numb_reg != '0);
        mag_next    = numb_reg[NW-1] ? NW'(-numb_reg) : NW'(numb_reg);
    end

    logic [NW-1:0] drem [0:QW];
    logic [DW-1:0] dden [0:QW];
    logic [QW-1:0] dquo [0:QW];
    side_t         dside [0:QW];
    logic [QW:0]   dvld;
    logic          vldc_reg;
    side_t         sidec_reg;
    logic [NW-1:0] remc_reg;
    logic [DW-1:0] denc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldc_reg <= 1'b0;
        else if (en_pipe)
            vldc_reg <= vldb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            sidec_reg <= sc_next;
            remc_reg  <= mag_next;
            denc_reg  <= denb_reg;
        end
    end

    assign dvld[0]  = vldc_reg;
    assign drem[0]  = remc_reg;
    assign dden[0]  = denc_reg;
    assign dquo[0]  = '0;
    assign dside[0] = sidec_reg;

    // ------------------------------------------------------------------
    // restoring divider cells, most significant quotient bit first
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        bucv_div_cell #(.BIT(QW-1-j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en_pipe),
            .vld_in   (dvld[j]),
            .rem_in   (drem[j]),
            .den_in   (dden[j]),
            .quo_in   (dquo[j]),
            .side_in  (dside[j]),
            .vld_out  (dvld[j+1]),
            .rem_out  (drem[j+1]),
            .den_out  (dden[j+1]),
            .quo_out  (dquo[j+1]),
            .side_out (dside[j+1])
        );
    end

    // ------------------------------------------------------------------
    // final: sign, clamp, flag
    side_t              fs;
    logic [QW-1:0]      fq;
    logic [15:0]        qmag;
    logic signed [15:0] o2_next;
    logic               f2_next;
    logic               fin_vld;

    assign fs      = dside[QW];
    assign fq      = dquo[QW];
    assign qmag    = fq[15:0];
    assign fin_vld = dvld[QW] && en_pipe;

    always_comb
    begin
        o2_next = '0;
        f2_next = 1'b0;
        if (fs.zdiv)
        begin
            f2_next = 1'b1;
            if (!fs.nz)
                o2_next = '0;
            else
                o2_next = fs.neg ? SAT_NEG : SAT_POS;
        end
        else if (fq[QW-1])
        begin
            f2_next = 1'b1;
            o2_next = fs.neg ? SAT_NEG : SAT_POS;
        end
        else if (!fs.neg)
        begin
            if (qmag[15])
            begin
                f2_next = 1'b1;
                o2_next = SAT_POS;
            end
            else
                o2_next = qmag;
        end
        else
        begin
            if (qmag > 16'h8000)
            begin
                f2_next = 1'b1;
                o2_next = SAT_NEG;
            end
            else
                o2_next = 16'(16'd0 - qmag);
        end
    end

    // ------------------------------------------------------------------
    // output register plus skid slot
    logic               out_vld_reg;
    logic signed [15:0] out_first_reg, out_second_reg;
    logic               sat_reg;
    logic signed [15:0] skid_first_reg, skid_second_reg;
    logic               skid_sat_reg;
    logic               out_take;

    assign out_take = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg <= fin_vld;
        end
        else if (fin_vld)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_vld_reg)
            begin
                out_first_reg  <= skid_first_reg;
                out_second_reg <= skid_second_reg;
                sat_reg        <= skid_sat_reg;
            end
            else
            begin
                out_first_reg  <= fs.o1;
                out_second_reg <= o2_next;
                sat_reg        <= fs.f1 | f2_next;
            end
        end
        else if (fin_vld)
        begin
            skid_first_reg  <= fs.o1;
            skid_second_reg <= o2_next;
            skid_sat_reg    <= fs.f1 | f2_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign saturated  = sat_reg;

    // ------------------------------------------------------------------
    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_stall && skid_vld_reg |=> out_vld_reg && !skid_vld_reg)
        else $error("skid result not moved to output after a transfer");

    a_zero_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fin_vld && out_take && !skid_vld_reg && fs.zdiv |=> saturated)
        else $error("zero divisor did not raise the saturation flag");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_WHEELBASE)
        |=> wheelbase_reg == $past(cfg_data))
        else $error("wheelbase write lost");

endmodule

@@ tb/bucv_checker.sv @@
`timescale 1ns / 1ps

module bucv_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] in_first,
    input  logic signed [15:0] in_second,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] out_first,
    input  logic signed [15:0] out_second,
    input  logic               saturated,
    output int                 err_count,
    output int                 pending,
    output int                 cmd_count,
    output int                 sat_count
);
    import bucv_pkg::*;

    localparam int STAGES = 16;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic               sat;
    } drive_cmd_t;

    drive_cmd_t cmd_q[$];
    logic [15:0] radius_q412;
    logic [15:0] base_q412;

    // floor shift right on 64-bit values
    function automatic longint floor_shr(longint a, int s);
        return a >>> s;
    endfunction

    function automatic longint clamp16(longint v, inout logic flag);
        if (v > 32767)
        begin
            flag = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint sign_limit(longint n);
        if (n > 0) return 32767;
        if (n < 0) return -32768;
        return 0;
    endfunction

    function automatic longint atan_step(int i);
        longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149,
                          1048576, 524288, 262144, 131072, 65536, 32768,
                          16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        return t[i];
    endfunction

    // vectoring: angle of (x, y), Q2.30
    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    // rotation: gain-scaled cos and sin of z
    function automatic void rotate_unit(longint z, output longint c, output longint s);
        longint x, y, xs, ys;
        x = 64'sd1 << 30;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic drive_cmd_t convert_cmd(logic m, longint a, longint b);
        drive_cmd_t res;
        longint r, wb, o1, o2, x, y, z, p, d, c, s, num;
        logic flag;
        r = radius_q412;
        wb = base_q412;
        flag = 1'b0;
        if (!m)
        begin
            if (b == 0)
                o1 = 0;
            else if (a == 0)
                o1 = (b > 0) ? 25736 : -25736;
            else
            begin
                x = (a < 0 ? -a : a) * 4096;
                y = wb * b;
                if (a < 0) y = -y;
                z = floor_shr(vector_angle(x, y) + 32768, 16);
                if (z > 25736) z = 25736;
                if (z < -25736) z = -25736;
                o1 = z;
            end
            if (r == 0)
            begin
                flag = 1'b1;
                o2 = sign_limit(a);
            end
            else
                o2 = clamp16((a * 4096) / r, flag);
        end
        else
        begin
            p = b * r;
            o1 = clamp16(floor_shr(p + 2048, 12), flag);
            d = a;
            if (d > 25736) d -= 51472;
            else if (d < -25736) d += 51472;
            rotate_unit(d * 65536, c, s);
            num = p * s;
            if (wb == 0 || c <= 0)
            begin
                flag = 1'b1;
                o2 = sign_limit(num);
            end
            else
                o2 = clamp16(num / (c * wb), flag);
        end
        res.first = o1[15:0];
        res.second = o2[15:0];
        res.sat = flag;
        return res;
    endfunction

    assign pending = cmd_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        drive_cmd_t want;
        if (!rst_n)
        begin
            radius_q412 <= GEOM_RESET;
            base_q412 <= GEOM_RESET;
            err_count = 0;
            cmd_count = 0;
            sat_count = 0;
            cmd_q.delete();
        end
        else
        begin
            // results first; an expectation queued this edge cannot be out yet
            if (out_valid && !out_stall)
            begin
                if (cmd_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected result %0d %0d %0b", $realtime,
                                 out_first, out_second, saturated);
                end
                else
                begin
                    want = cmd_q.pop_front();
                    if (want.sat) sat_count++;
                    if (out_first !== want.first || out_second !== want.second
                        || saturated !== want.sat)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: mismatch exp %0d %0d %0b got %0d %0d %0b",
                                     $realtime, want.first, want.second, want.sat,
                                     out_first, out_second, saturated);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                cmd_q.push_back(convert_cmd(mode, in_first, in_second));
                cmd_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WHEEL_RADIUS)
                    radius_q412 <= cfg_data;
                else
                    base_q412 <= cfg_data;
            end
        end
    end

endmodule

@@ tb/tb_bicycle_unicycle_kinematic_convert.sv @@
`timescale 1ns / 1ps

module tb_bicycle_unicycle_kinematic_convert;
    import bucv_pkg::*;

    localparam int LATENCY = 37;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [0:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic signed [15:0] in_first;
    logic signed [15:0] in_second;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] out_first;
    logic signed [15:0] out_second;
    logic               saturated;
    int                 err_count;
    int                 pending;
    int                 cmd_count;
    int                 sat_count;
    logic               calm;

    bicycle_unicycle_kinematic_convert DUT (.*);

    bucv_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb_bicycle_unicycle_kinematic_convert: done, errors");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one command transfer, with an optional sender gap before it
    task automatic send_cmd(logic m, logic [15:0] a, logic [15:0] b);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        in_first <= a;
        in_second <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_geom(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            3: return 16'($signed($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] geo [8];
        logic [15:0] edges [6];
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WHEEL_RADIUS;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = 1'b0;
        in_first = '0;
        in_second = '0;
        geo = '{16'd4096, 16'd0, 16'hffff, 16'd1, 16'd256, 16'd2048, 16'd12000,
                16'd4096};
        edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h6488};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero turn, zero speed, extremes, angle wrap, both modes
        for (int m = 0; m < 2; m++)
            for (int i = 0; i < 6; i++)
                send_cmd(m[0], edges[i], edges[(i * 5 + 1) % 6]);
        send_cmd(1'b0, 16'h0000, 16'h0000);
        send_cmd(1'b0, 16'h0000, 16'hff00);
        send_cmd(1'b1, 16'h9b00, 16'h0100);
        send_cmd(1'b1, 16'h6488, 16'h0100);
        drain();

        // phases over geometry settings, zero radius and base among them
        for (int ph = 0; ph < 8; ph++)
        begin
            write_geom(REG_WHEEL_RADIUS, geo[ph]);
            write_geom(REG_WHEELBASE, geo[(ph + 3) % 8]);
            if (ph == 7) calm = 1'b1;
            for (int k = 0; k < 190; k++)
                send_cmd(1'($urandom), pick16(), pick16());
            drain();
        end

        $display("covered %0d commands over 8 geometry settings, %0d saturated results",
                 cmd_count, sat_count);
        if (err_count == 0)
            $display("tb_bicycle_unicycle_kinematic_convert: done, clean");
        else
            $display("tb_bicycle_unicycle_kinematic_convert: done, errors");
        $finish;
    end

endmodule
